FILE: rtl/isq_pkg.sv
// Shared types and constants for the indexed sorted priority queue.
// Operation codes, result status codes and the per-cell action code.
// Depends on nothing; every other file imports it.
package isq_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int VERTICES_DEF = 64;
	localparam int KEY_W        = 32;
	localparam int OP_W         = 3;
	localparam int ST_W         = 2;

	localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
	localparam logic [OP_W-1:0] OP_POP    = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
	localparam logic [OP_W-1:0] OP_LOOKUP = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
	localparam logic [ST_W-1:0] ST_NOVERTEX = 2'd3;

	// What every cell does on the update cycle.
	typedef enum logic [2:0] {
		ACT_HOLD,
		ACT_PUSH,
		ACT_POP,
		ACT_DROP,
		ACT_CLEAR
	} act_t;

endpackage

FILE: rtl/isq_cell.sv
// One slot of the sorted row: holds an entry and its index mark.
// Compares itself against the broadcast key and vertex, and takes data
// from its left or right neighbor when the row shifts. Uses isq_pkg.
module isq_cell #(
	parameter int VW = 6
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  isq_pkg::act_t            act,
	input  logic [VW-1:0]            sel_vertex,
	input  logic [isq_pkg::KEY_W-1:0] sel_key,
	input  logic [VW-1:0]            new_connection,
	input  logic                     after,
	input  logic                     left_gt,
	input  logic                     left_vm,
	input  logic                     left_valid,
	input  logic                     left_indexed,
	input  logic [VW-1:0]            left_vertex,
	input  logic [isq_pkg::KEY_W-1:0] left_key,
	input  logic [VW-1:0]            left_connection,
	input  logic                     right_vm,
	input  logic                     right_valid,
	input  logic                     right_indexed,
	input  logic [VW-1:0]            right_vertex,
	input  logic [isq_pkg::KEY_W-1:0] right_key,
	input  logic [VW-1:0]            right_connection,
	output logic                     gt,
	output logic                     vm,
	output logic                     valid,
	output logic                     indexed,
	output logic [VW-1:0]            vertex,
	output logic [isq_pkg::KEY_W-1:0] key,
	output logic [VW-1:0]            connection
);
	import isq_pkg::*;

	logic              valid_q;
	logic              indexed_q;
	logic [VW-1:0]     vertex_q;
	logic [KEY_W-1:0]  key_q;
	logic [VW-1:0]     connection_q;

	logic              valid_nx;
	logic              indexed_nx;
	logic              load;
	logic [VW-1:0]     vertex_nx;
	logic [KEY_W-1:0]  key_nx;
	logic [VW-1:0]     connection_nx;

	// Empty slots sort after everything, so gt is monotonic along the row.
	assign gt = !valid_q || (key_q > sel_key) || (key_q == sel_key && vertex_q > sel_vertex);
	assign vm = (vertex_q == sel_vertex);

	always_comb begin
		valid_nx      = valid_q;
		indexed_nx    = indexed_q;
		load          = 1'b0;
		vertex_nx     = vertex_q;
		key_nx        = key_q;
		connection_nx = connection_q;
		case (act)
			ACT_PUSH: begin
				if (gt && !left_gt) begin
					valid_nx      = 1'b1;
					indexed_nx    = 1'b1;
					load          = 1'b1;
					vertex_nx     = sel_vertex;
					key_nx        = sel_key;
					connection_nx = new_connection;
				end else if (gt) begin
					valid_nx      = left_valid;
					indexed_nx    = left_indexed && !left_vm;
					load          = 1'b1;
					vertex_nx     = left_vertex;
					key_nx        = left_key;
					connection_nx = left_connection;
				end else begin
					indexed_nx = indexed_q && !vm;
				end
			end
			ACT_POP: begin
				// shift toward the head and drop marks of the popped vertex
				valid_nx      = right_valid;
				indexed_nx    = right_indexed && !right_vm;
				load          = 1'b1;
				vertex_nx     = right_vertex;
				key_nx        = right_key;
				connection_nx = right_connection;
			end
			ACT_DROP: begin
				if (after) begin
					valid_nx      = right_valid;
					indexed_nx    = right_indexed;
					load          = 1'b1;
					vertex_nx     = right_vertex;
					key_nx        = right_key;
					connection_nx = right_connection;
				end
			end
			ACT_CLEAR: begin
				valid_nx   = 1'b0;
				indexed_nx = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			indexed_q <= 1'b0;
		end else begin
			valid_q   <= valid_nx;
			indexed_q <= indexed_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			vertex_q     <= vertex_nx;
			key_q        <= key_nx;
			connection_q <= connection_nx;
		end
	end

	assign valid      = valid_q;
	assign indexed    = indexed_q;
	assign vertex     = vertex_q;
	assign key        = key_q;
	assign connection = connection_q;

endmodule

FILE: rtl/indexed_sorted_priority_queue.sv
// Indexed sorted priority queue: a row of CAPACITY cells kept in key order.
// An accepted operation is held for the update cycle, in which the row and the
// result registers load together; done then rises with the result.
// Busy is high for the update cycle; no operation is taken while busy is high.
// Reset empties the queue and drops all marks at once; no clearing pass.
// Results cannot be stalled: done is a one-cycle strobe; result fields persist.
module indexed_sorted_priority_queue #(
	parameter int CAPACITY = isq_pkg::CAPACITY_DEF,
	parameter int VERTICES = isq_pkg::VERTICES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [isq_pkg::OP_W-1:0]          op,
	input  logic [$clog2(VERTICES)-1:0]       vertex,
	input  logic [isq_pkg::KEY_W-1:0]         key,
	input  logic [$clog2(VERTICES)-1:0]       connection,
	output logic                              done,
	output logic                              found,
	output logic [$clog2(VERTICES)-1:0]       out_vertex,
	output logic [isq_pkg::KEY_W-1:0]         out_key,
	output logic [$clog2(VERTICES)-1:0]       out_connection,
	output logic                              is_empty,
	output logic [isq_pkg::ST_W-1:0]          status
);
	import isq_pkg::*;

	localparam int VW   = $clog2(VERTICES);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int LVLS = $clog2(CAPACITY);
	localparam logic [VW:0]   VLIM    = (VW + 1)'(VERTICES);
	localparam logic [CW-1:0] CNT_MAX = CW'(CAPACITY);

	// accepted operation, held for the update cycle
	logic              s1_valid_q;
	logic [OP_W-1:0]   op_s1;
	logic [VW-1:0]     vertex_s1;
	logic [KEY_W-1:0]  key_s1;
	logic [VW-1:0]     connection_s1;

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_nx;

	act_t              act;
	logic [VW-1:0]     sel_vertex;
	logic              vok;
	logic              any_hit;

	logic [CAPACITY-1:0] c_gt;
	logic [CAPACITY-1:0] c_vm;
	logic [CAPACITY-1:0] c_valid;
	logic [CAPACITY-1:0] c_indexed;
	logic [CAPACITY-1:0] hit;
	logic [VW-1:0]       c_vertex     [CAPACITY];
	logic [KEY_W-1:0]    c_key        [CAPACITY];
	logic [VW-1:0]       c_connection [CAPACITY];
	logic [CAPACITY-1:0] pre [LVLS+1];

	logic              res_found;
	logic [VW-1:0]     res_vertex;
	logic [KEY_W-1:0]  res_key;
	logic [VW-1:0]     res_connection;
	logic [ST_W-1:0]   res_status;
	logic [VW-1:0]     look_vertex;
	logic [KEY_W-1:0]  look_key;
	logic [VW-1:0]     look_connection;

	logic              done_q;
	logic              found_q;
	logic [VW-1:0]     out_vertex_q;
	logic [KEY_W-1:0]  out_key_q;
	logic [VW-1:0]     out_connection_q;
	logic              is_empty_q;
	logic [ST_W-1:0]   status_q;

	assign busy = s1_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= start && !s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !s1_valid_q) begin
			op_s1         <= op;
			vertex_s1     <= vertex;
			key_s1        <= key;
			connection_s1 <= connection;
		end
	end

	assign vok        = ({1'b0, vertex_s1} < VLIM);
	// pop compares against the head so its marks can be dropped during the shift
	assign sel_vertex = (op_s1 == OP_POP) ? c_vertex[0] : vertex_s1;

	genvar gi, gl;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic              l_gt, l_vm, l_valid, l_indexed;
			logic [VW-1:0]     l_vertex, l_connection;
			logic [KEY_W-1:0]  l_key;
			logic              r_vm, r_valid, r_indexed;
			logic [VW-1:0]     r_vertex, r_connection;
			logic [KEY_W-1:0]  r_key;

			if (gi == 0) begin : g_head
				assign l_gt         = 1'b0;
				assign l_vm         = 1'b0;
				assign l_valid      = 1'b0;
				assign l_indexed    = 1'b0;
				assign l_vertex     = '0;
				assign l_key        = '0;
				assign l_connection = '0;
			end else begin : g_left
				assign l_gt         = c_gt[gi-1];
				assign l_vm         = c_vm[gi-1];
				assign l_valid      = c_valid[gi-1];
				assign l_indexed    = c_indexed[gi-1];
				assign l_vertex     = c_vertex[gi-1];
				assign l_key        = c_key[gi-1];
				assign l_connection = c_connection[gi-1];
			end

			if (gi == CAPACITY - 1) begin : g_tail
				assign r_vm         = 1'b0;
				assign r_valid      = 1'b0;
				assign r_indexed    = 1'b0;
				assign r_vertex     = '0;
				assign r_key        = '0;
				assign r_connection = '0;
			end else begin : g_right
				assign r_vm         = c_vm[gi+1];
				assign r_valid      = c_valid[gi+1];
				assign r_indexed    = c_indexed[gi+1];
				assign r_vertex     = c_vertex[gi+1];
				assign r_key        = c_key[gi+1];
				assign r_connection = c_connection[gi+1];
			end

			isq_cell #(
				.VW(VW)
			) u_cell (
				.clk              (clk),
				.arst_n           (arst_n),
				.act              (act),
				.sel_vertex       (sel_vertex),
				.sel_key          (key_s1),
				.new_connection   (connection_s1),
				.after            (pre[LVLS][gi]),
				.left_gt          (l_gt),
				.left_vm          (l_vm),
				.left_valid       (l_valid),
				.left_indexed     (l_indexed),
				.left_vertex      (l_vertex),
				.left_key         (l_key),
				.left_connection  (l_connection),
				.right_vm         (r_vm),
				.right_valid      (r_valid),
				.right_indexed    (r_indexed),
				.right_vertex     (r_vertex),
				.right_key        (r_key),
				.right_connection (r_connection),
				.gt               (c_gt[gi]),
				.vm               (c_vm[gi]),
				.valid            (c_valid[gi]),
				.indexed          (c_indexed[gi]),
				.vertex           (c_vertex[gi]),
				.key              (c_key[gi]),
				.connection       (c_connection[gi])
			);

			assign hit[gi] = c_vm[gi] && c_valid[gi] && c_indexed[gi];
		end

		// log-depth prefix OR: a cell at or after the removed one shifts
		assign pre[0] = hit;
		for (gl = 0; gl < LVLS; gl++) begin : g_lvl
			for (gi = 0; gi < CAPACITY; gi++) begin : g_bit
				if (gi >= (1 << gl)) begin : g_or
					assign pre[gl+1][gi] = pre[gl][gi] | pre[gl][gi - (1 << gl)];
				end else begin : g_pass
					assign pre[gl+1][gi] = pre[gl][gi];
				end
			end
		end
	endgenerate

	assign any_hit = |hit;

	// at most one cell matches, so an AND-OR selects it
	always_comb begin
		look_vertex     = '0;
		look_key        = '0;
		look_connection = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			look_vertex     = look_vertex | ({VW{hit[i]}} & c_vertex[i]);
			look_key        = look_key | ({KEY_W{hit[i]}} & c_key[i]);
			look_connection = look_connection | ({VW{hit[i]}} & c_connection[i]);
		end
	end

	always_comb begin
		act            = ACT_HOLD;
		count_nx       = count_q;
		res_found      = 1'b0;
		res_vertex     = '0;
		res_key        = '0;
		res_connection = '0;
		res_status     = ST_OK;
		case (op_s1)
			OP_PUSH: begin
				if (!vok) begin
					res_status = ST_NOVERTEX;
				end else if (count_q == CNT_MAX) begin
					res_status = ST_FULL;
				end else begin
					act      = ACT_PUSH;
					count_nx = count_q + CW'(1);
				end
			end
			OP_POP: begin
				if (count_q == '0) begin
					res_status = ST_EMPTY;
				end else begin
					act            = ACT_POP;
					count_nx       = count_q - CW'(1);
					res_found      = 1'b1;
					res_vertex     = c_vertex[0];
					res_key        = c_key[0];
					res_connection = c_connection[0];
				end
			end
			OP_REMOVE: begin
				if (!vok || !any_hit) begin
					res_status = ST_NOVERTEX;
				end else begin
					act      = ACT_DROP;
					count_nx = count_q - CW'(1);
				end
			end
			OP_LOOKUP: begin
				if (!vok || !any_hit) begin
					res_status = ST_NOVERTEX;
				end else begin
					res_found      = 1'b1;
					res_vertex     = look_vertex;
					res_key        = look_key;
					res_connection = look_connection;
				end
			end
			OP_CLEAR: begin
				act      = ACT_CLEAR;
				count_nx = '0;
			end
			default: begin
			end
		endcase
		// hold everything outside the update cycle
		if (!s1_valid_q) begin
			act      = ACT_HOLD;
			count_nx = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nx;
			done_q  <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q) begin
			found_q          <= res_found;
			out_vertex_q     <= res_vertex;
			out_key_q        <= res_key;
			out_connection_q <= res_connection;
			is_empty_q       <= (count_nx == '0);
			status_q         <= res_status;
		end
	end

	assign done           = done_q;
	assign found          = found_q;
	assign out_vertex     = out_vertex_q;
	assign out_key        = out_key_q;
	assign out_connection = out_connection_q;
	assign is_empty       = is_empty_q;
	assign status         = status_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("entry count above capacity");

	a_packed_row: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(c_valid) == 32'(count_q))
		else $error("occupied cells do not match entry count");

	a_single_mark: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> $onehot0(hit))
		else $error("vertex marked in more than one cell");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted beat gave no result");

endmodule

FILE: test/tb_indexed_sorted_priority_queue.sv
// Self-checking testbench for the indexed sorted priority queue: directed corner beats, then
// weighted random push/pop/remove/lookup/clear/spare-op traffic against an in-bench sorted-row model.
// Depends on isq_pkg and the indexed_sorted_priority_queue RTL.
module tb_indexed_sorted_priority_queue;
	timeunit 1ns;
	timeprecision 1ps;
	import isq_pkg::*;

	localparam int CAP          = CAPACITY_DEF;
	localparam int VW           = $clog2(VERTICES_DEF);
	localparam int RANDOM_OPS   = 950;
	localparam int CALM_TAIL    = 100;
	localparam int SETTLE_TICKS = 6;
	localparam int CYCLE_LIMIT  = 200000;
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIX} seg_t;

	typedef struct {
		logic [OP_W-1:0]  op;
		logic [VW-1:0]    vtx;
		logic [KEY_W-1:0] key;
		logic [VW-1:0]    conn;
	} qop_t;

	typedef struct {
		logic             found;
		logic [VW-1:0]    vtx;
		logic [KEY_W-1:0] key;
		logic [VW-1:0]    conn;
		logic             empty;
		logic [ST_W-1:0]  st;
	} answer_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [OP_W-1:0]  op = '0;
	logic [VW-1:0]    vertex = '0;
	logic [KEY_W-1:0] key = '0;
	logic [VW-1:0]    connection = '0;
	logic             busy;
	logic             done;
	logic             found;
	logic [VW-1:0]    out_vertex;
	logic [KEY_W-1:0] out_key;
	logic [VW-1:0]    out_connection;
	logic             is_empty;
	logic [ST_W-1:0]  status;

	qop_t    op_backlog[$];
	answer_t due_answers[$];
	bit      taken = 1'b0;
	int      gap_left = 0;
	int      ops_taken = 0;
	int      ops_total = 0;
	int      errors = 0;
	int      cycles = 0;

	// sorted row mirror: cells 0..row_len-1 are live
	logic [VW-1:0]    row_vtx[CAP];
	logic [KEY_W-1:0] row_key[CAP];
	logic [VW-1:0]    row_conn[CAP];
	bit               row_mark[CAP];
	int               row_len = 0;

	int n_found = 0, n_full = 0, n_empty = 0, n_unmarked = 0, n_clear = 0, deepest = 0;

	indexed_sorted_priority_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.vertex(vertex),
		.key(key),
		.connection(connection),
		.done(done),
		.found(found),
		.out_vertex(out_vertex),
		.out_key(out_key),
		.out_connection(out_connection),
		.is_empty(is_empty),
		.status(status)
	);

	always #10 clk = ~clk;

	function automatic void row_close_gap(int pos);
		for (int i = pos; i + 1 < row_len; i++) begin
			row_vtx[i]  = row_vtx[i+1];
			row_key[i]  = row_key[i+1];
			row_conn[i] = row_conn[i+1];
			row_mark[i] = row_mark[i+1];
		end
		row_len--;
		row_mark[row_len] = 1'b0;
	endfunction

	function automatic void row_unmark(logic [VW-1:0] v);
		for (int i = 0; i < row_len; i++)
			if (row_vtx[i] == v)
				row_mark[i] = 1'b0;
	endfunction

	function automatic answer_t queue_apply_op(qop_t q);
		answer_t a;
		int pos;
		a = '{default: '0};
		a.st = ST_OK;
		if (q.op == OP_PUSH) begin
			if (row_len >= CAP) begin
				a.st = ST_FULL;
				n_full++;
			end else begin
				pos = 0;
				while (pos < row_len && (row_key[pos] < q.key ||
						(row_key[pos] == q.key && row_vtx[pos] <= q.vtx)))
					pos++;
				row_unmark(q.vtx);
				for (int i = row_len; i > pos; i--) begin
					row_vtx[i]  = row_vtx[i-1];
					row_key[i]  = row_key[i-1];
					row_conn[i] = row_conn[i-1];
					row_mark[i] = row_mark[i-1];
				end
				row_vtx[pos]  = q.vtx;
				row_key[pos]  = q.key;
				row_conn[pos] = q.conn;
				row_mark[pos] = 1'b1;
				row_len++;
				if (row_len > deepest)
					deepest = row_len;
			end
		end else if (q.op == OP_POP) begin
			if (row_len == 0) begin
				a.st = ST_EMPTY;
				n_empty++;
			end else begin
				a.found = 1'b1;
				a.vtx   = row_vtx[0];
				a.key   = row_key[0];
				a.conn  = row_conn[0];
				row_close_gap(0);
				// popping the head strips the mark from every entry of its vertex
				row_unmark(a.vtx);
				n_found++;
			end
		end else if (q.op == OP_REMOVE || q.op == OP_LOOKUP) begin
			pos = row_len;
			for (int i = row_len - 1; i >= 0; i--)
				if (row_mark[i] && row_vtx[i] == q.vtx)
					pos = i;
			if (pos >= row_len) begin
				a.st = ST_NOVERTEX;
				n_unmarked++;
			end else if (q.op == OP_REMOVE) begin
				row_close_gap(pos);
			end else begin
				a.found = 1'b1;
				a.vtx   = row_vtx[pos];
				a.key   = row_key[pos];
				a.conn  = row_conn[pos];
				n_found++;
			end
		end else if (q.op == OP_CLEAR) begin
			for (int i = 0; i < CAP; i++)
				row_mark[i] = 1'b0;
			row_len = 0;
			n_clear++;
		end
		a.empty = (row_len == 0);
		return a;
	endfunction

	function automatic qop_t make_op(logic [OP_W-1:0] o, int v, logic [KEY_W-1:0] k, int c);
		qop_t q;
		q.op   = o;
		q.vtx  = VW'(v);
		q.key  = k;
		q.conn = VW'(c);
		return q;
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return KEY_W'($urandom_range(0, 7));
		if (r == 4)
			return $urandom_range(0, 1) ? '1 : '0;
		return $urandom;
	endfunction

	function automatic qop_t pick_op(seg_t seg, int vspan);
		int r;
		logic [OP_W-1:0] o;
		r = $urandom_range(0, 99);
		case (seg)
			SEG_FILL: begin
				o = r < 85 ? OP_PUSH : r < 90 ? OP_POP : r < 95 ? OP_LOOKUP : OP_REMOVE;
			end
			SEG_DRAIN: begin
				o = r < 10 ? OP_PUSH : r < 75 ? OP_POP : r < 88 ? OP_LOOKUP : OP_REMOVE;
			end
			default: begin
				if (r < 40)
					o = OP_PUSH;
				else if (r < 62)
					o = OP_POP;
				else if (r < 78)
					o = OP_REMOVE;
				else if (r < 95)
					o = OP_LOOKUP;
				else if (r < 97)
					o = OP_CLEAR;
				else
					o = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
			end
		endcase
		return make_op(o, $urandom_range(0, vspan - 1), pick_key(),
			$urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, (1 << VW) - 1));
	endfunction

	// accept a beat and queue its predicted answer
	always @(posedge clk) begin
		taken = 1'b0;
		if (arst_n && start && !busy) begin
			due_answers.push_back(queue_apply_op(make_op(op, int'(vertex), key,
				int'(connection))));
			taken = 1'b1;
			ops_taken++;
		end
	end

	// driver: hold an offered beat until taken, idle in bursts, scramble idle fields
	always @(negedge clk) begin : drive
		qop_t nxt;
		bit launch;
		launch = 1'b0;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!(start && !taken)) begin
			if (gap_left > 0)
				gap_left--;
			else if (op_backlog.size() != 0) begin
				if (op_backlog.size() > CALM_TAIL && $urandom_range(0, 11) == 0)
					gap_left = $urandom_range(0, 12);
				else
					launch = 1'b1;
			end
			if (launch) begin
				nxt = op_backlog.pop_front();
				start      <= 1'b1;
				op         <= nxt.op;
				vertex     <= nxt.vtx;
				key        <= nxt.key;
				connection <= nxt.conn;
			end else begin
				start      <= 1'b0;
				op         <= OP_W'($urandom);
				vertex     <= VW'($urandom);
				key        <= $urandom;
				connection <= VW'($urandom);
			end
		end
	end

	task automatic check_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		end
	endtask

	// monitor: every done beat must match the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin : observe
			answer_t want;
			if (due_answers.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, expected none got status %0d",
					$time, status);
			end else begin
				want = due_answers.pop_front();
				check_field("found", KEY_W'(want.found), KEY_W'(found));
				check_field("out_vertex", KEY_W'(want.vtx), KEY_W'(out_vertex));
				check_field("out_key", want.key, out_key);
				check_field("out_connection", KEY_W'(want.conn), KEY_W'(out_connection));
				check_field("is_empty", KEY_W'(want.empty), KEY_W'(is_empty));
				check_field("status", KEY_W'(want.st), KEY_W'(status));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("run stalled after %0d cycles with %0d answers outstanding",
				cycles, due_answers.size());
			$display("tb_indexed_sorted_priority_queue: errors");
			$finish;
		end
	end

	initial begin
		int counted;
		int seg_len;
		int vspan;
		seg_t seg;
		qop_t q;

		// empty-queue misses
		op_backlog.push_back(make_op(OP_POP, 0, '0, 0));
		op_backlog.push_back(make_op(OP_LOOKUP, 5, '0, 0));
		op_backlog.push_back(make_op(OP_REMOVE, 5, '0, 0));
		// key extremes, ties on key, full tie keeps push order, re-mark of a vertex
		op_backlog.push_back(make_op(OP_PUSH, 63, '1, 63));
		op_backlog.push_back(make_op(OP_PUSH, 0, '0, 0));
		op_backlog.push_back(make_op(OP_PUSH, 10, 32'd100, 1));
		op_backlog.push_back(make_op(OP_PUSH, 3, 32'd100, 2));
		op_backlog.push_back(make_op(OP_PUSH, 10, 32'd100, 3));
		op_backlog.push_back(make_op(OP_LOOKUP, 10, '0, 0));
		op_backlog.push_back(make_op(OP_PUSH, 10, 32'd50, 4));
		op_backlog.push_back(make_op(OP_LOOKUP, 10, '0, 0));
		op_backlog.push_back(make_op(OP_REMOVE, 10, '0, 0));
		op_backlog.push_back(make_op(OP_LOOKUP, 10, '0, 0));
		op_backlog.push_back(make_op(OP_POP, 0, '0, 0));
		op_backlog.push_back(make_op(OP_POP, 0, '0, 0));
		// a popped vertex is no longer found by lookup
		op_backlog.push_back(make_op(OP_PUSH, 3, '0, 5));
		op_backlog.push_back(make_op(OP_POP, 0, '0, 0));
		op_backlog.push_back(make_op(OP_LOOKUP, 3, '0, 0));
		op_backlog.push_back(make_op(OP_SPARE_LO, 7, 32'h1234, 9));
		op_backlog.push_back(make_op(OP_SPARE_HI, 63, '1, 63));
		op_backlog.push_back(make_op(OP_CLEAR, 0, '0, 0));
		op_backlog.push_back(make_op(OP_POP, 0, '0, 0));
		op_backlog.push_back(make_op(OP_PUSH, 42, 32'hAAAA_AAAA, 42));
		op_backlog.push_back(make_op(OP_PUSH, 21, 32'h5555_5555, 21));
		op_backlog.push_back(make_op(OP_LOOKUP, 42, '0, 0));

		// random part in segments that push toward full, toward empty, or mix
		counted = 0;
		while (counted < RANDOM_OPS) begin
			seg = seg_t'($urandom_range(0, 2));
			seg_len = $urandom_range(20, 90);
			vspan = $urandom_range(0, 1) ? 8 : (1 << VW);
			repeat (seg_len) begin
				q = pick_op(seg, vspan);
				op_backlog.push_back(q);
				if (q.op <= OP_CLEAR)
					counted++;
			end
		end
		ops_total = op_backlog.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (ops_taken != ops_total || due_answers.size() != 0)
			@(negedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);

		$display("ran %0d operations: %0d entries returned, %0d clears, deepest queue %0d",
			ops_total, n_found, n_clear, deepest);
		$display("misses seen: %0d push on full, %0d pop on empty, %0d unmarked vertex",
			n_full, n_empty, n_unmarked);
		if (errors == 0)
			$display("tb_indexed_sorted_priority_queue: clean");
		else
			$display("tb_indexed_sorted_priority_queue: errors");
		$finish;
	end

endmodule

FILE: files.f
rtl/isq_pkg.sv
rtl/isq_cell.sv
rtl/indexed_sorted_priority_queue.sv
test/tb_indexed_sorted_priority_queue.sv
